// ===== src/key_press_state_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Key press state tracker assertion macros
// Concurrent assertion wrappers clocked on aclk; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_STATE_TRACKER_ASSERT_SVH
`define KEY_PRESS_STATE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define KPST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define KPST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define KPST_ASSERT(lbl, prop, msg)
`define KPST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/kpst_pkg.sv =====
// ----------------------------------------------------------------------------
// Key press state tracker package
// Shared widths, default sizes, operation codes and key state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kpst_pkg;

    localparam int KPST_PENDING_DEPTH = 16;
    localparam int KPST_KEY_COUNT     = 256;

    localparam int FUNC_W      = 3;
    localparam int KEY_W       = 8;
    localparam int KS_W        = 3;
    localparam int KEY_LIMIT_W = 11;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PRESS   = 3'd0,
        FUNC_RELEASE = 3'd1,
        FUNC_TICK    = 3'd2,
        FUNC_QUERY   = 3'd3,
        FUNC_CLEAR   = 3'd4
    } func_t;

    localparam logic [KS_W-1:0] KS_NONE = 3'd0;
    localparam logic [KS_W-1:0] KS_ONCE = 3'd1;
    localparam logic [KS_W-1:0] KS_HOLD = 3'd2;
    localparam logic [KS_W-1:0] KS_LIFT = 3'd3;
    localparam logic [KS_W-1:0] KS_SNAP = 3'd4;
    localparam logic [KS_W-1:0] KS_FLAP = 3'd5;

endpackage

`default_nettype wire

// ===== src/key_press_state_tracker.sv =====
// ----------------------------------------------------------------------------
// Key press state tracker
// Keeps a six-state press machine for each key in a synchronous memory and
// a list of keys changed since the last frame tick in a second memory.
//
//   Channel  Direction  Payload
//   s_       in         tuser: func[2:0]; tdata: key_code[7:0]
//   m_       out        tdata: key_state[2:0], zero padded to 8 bits
//
// Press, release and query first read the key memory, then modify, write back
// and load the output register.
// A frame tick reads each pending entry, then its key, and writes the settled
// state back; clear all empties the pending list and sweeps the key memory.
// After reset the same sweep runs before any word is accepted. A stalled output
// holds one word in the output register and the next in a result register, and
// the input side then waits with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_state_tracker
    import kpst_pkg::*;
#(
    parameter int PENDING_DEPTH = KPST_PENDING_DEPTH,
    parameter int KEY_COUNT     = KPST_KEY_COUNT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // key_code[7:0]
    input  wire logic [FUNC_W-1:0] s_tuser,   // func[2:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata    // key_state[2:0], zeros above
);

    localparam int KAW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW  = $clog2(PENDING_DEPTH + 1);
    localparam logic [KEY_LIMIT_W-1:0] KEY_LIMIT = KEY_LIMIT_W'(KEY_COUNT);
    localparam logic [KAW-1:0]         KEY_LAST  = KAW'(KEY_COUNT - 1);
    localparam logic [CW-1:0]          PEND_FULL = CW'(PENDING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOOKUP,
        S_TICK_KEY,
        S_TICK_SET,
        S_OUT
    } state_t;

    state_t            state_reg;
    func_t             func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  tkey_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     count_reg;
    logic [KAW-1:0]    clr_addr_reg;
    logic              clr_out_reg;
    logic [KS_W-1:0]   res_reg;
    logic              m_tvalid_reg;
    logic [KS_W-1:0]   m_tdata_reg;

    logic [KS_W-1:0]   key_mem [KEY_COUNT];
    logic [KS_W-1:0]   key_rdata_reg;
    logic [KEY_W-1:0]  pend_mem [PENDING_DEPTH];
    logic [KEY_W-1:0]  pend_rdata_reg;

    logic              key_re;
    logic [KAW-1:0]    key_raddr;
    logic              key_we;
    logic [KAW-1:0]    key_waddr;
    logic [KS_W-1:0]   key_wdata;
    logic              pend_re;
    logic [PAW-1:0]    pend_raddr;
    logic              pend_we;

    logic              accept;
    func_t             in_func;
    logic              in_range;
    logic              out_free;
    logic              out_load;
    logic [KS_W-1:0]   edit_state;
    logic              edit_changed;
    logic [KS_W-1:0]   query_state;
    logic [KS_W-1:0]   settled_state;
    logic [CW-1:0]     idx_inc;

    function automatic logic [KS_W-1:0] press_next(input logic [KS_W-1:0] s);
        logic [KS_W-1:0] n;
        n = s;
        if (s == KS_NONE) begin
            n = KS_ONCE;
        end else if (s == KS_LIFT || s == KS_SNAP) begin
            n = KS_FLAP;
        end
        return n;
    endfunction

    function automatic logic [KS_W-1:0] release_next(input logic [KS_W-1:0] s);
        logic [KS_W-1:0] n;
        n = s;
        if (s == KS_HOLD) begin
            n = KS_LIFT;
        end else if (s == KS_ONCE || s == KS_FLAP) begin
            n = KS_SNAP;
        end
        return n;
    endfunction

    function automatic logic [KS_W-1:0] settle(input logic [KS_W-1:0] s);
        logic [KS_W-1:0] n;
        n = s;
        if (s == KS_ONCE || s == KS_FLAP) begin
            n = KS_HOLD;
        end else if (s == KS_LIFT || s == KS_SNAP) begin
            n = KS_NONE;
        end
        return n;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_func  = func_t'(s_tuser);
    assign in_range = {{(KEY_LIMIT_W - KEY_W){1'b0}}, s_tdata} < KEY_LIMIT;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_LOOKUP || state_reg == S_OUT) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - KS_W){1'b0}}, m_tdata_reg};
    assign idx_inc  = CW'(idx_reg + 1'b1);

    always_comb begin
        edit_state = (func_reg == FUNC_PRESS) ? press_next(key_rdata_reg)
                                              : release_next(key_rdata_reg);
        edit_changed = (func_reg == FUNC_PRESS || func_reg == FUNC_RELEASE) &&
                       (edit_state != key_rdata_reg);
        if (func_reg != FUNC_QUERY || key_reg == '0) begin
            query_state = KS_NONE;
        end else if (key_rdata_reg == KS_FLAP) begin
            query_state = KS_SNAP;
        end else begin
            query_state = key_rdata_reg;
        end
        settled_state = settle(key_rdata_reg);
    end

    always_comb begin
        key_re     = 1'b0;
        key_raddr  = KAW'(s_tdata);
        key_we     = 1'b0;
        key_waddr  = KAW'(key_reg);
        key_wdata  = edit_state;
        pend_re    = 1'b0;
        pend_raddr = '0;
        pend_we    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_range && (in_func == FUNC_PRESS ||
                    in_func == FUNC_RELEASE || in_func == FUNC_QUERY)) begin
                    key_re = 1'b1;
                end
                if (accept && in_func == FUNC_TICK && count_reg != '0) begin
                    pend_re = 1'b1;
                end
            end
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = clr_addr_reg;
                key_wdata = KS_NONE;
            end
            S_LOOKUP: begin
                key_we  = edit_changed;
                pend_we = edit_changed && (count_reg < PEND_FULL);
            end
            S_TICK_KEY: begin
                key_re    = 1'b1;
                key_raddr = KAW'(pend_rdata_reg);
            end
            S_TICK_SET: begin
                key_we     = (settled_state != key_rdata_reg);
                key_waddr  = KAW'(tkey_reg);
                key_wdata  = settled_state;
                pend_re    = (idx_inc != count_reg);
                pend_raddr = idx_inc[PAW-1:0];
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (key_re) begin
            key_rdata_reg <= key_mem[key_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[count_reg[PAW-1:0]] <= key_reg;
        end
        if (pend_re) begin
            pend_rdata_reg <= pend_mem[pend_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            clr_out_reg  <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        func_reg <= in_func;
                        key_reg  <= s_tdata;
                        res_reg  <= KS_NONE;
                        unique case (in_func) inside
                            FUNC_PRESS, FUNC_RELEASE, FUNC_QUERY: begin
                                state_reg <= in_range ? S_LOOKUP : S_OUT;
                            end
                            FUNC_TICK: begin
                                idx_reg   <= '0;
                                state_reg <= (count_reg == '0) ? S_OUT : S_TICK_KEY;
                            end
                            FUNC_CLEAR: begin
                                count_reg    <= '0;
                                clr_addr_reg <= '0;
                                clr_out_reg  <= 1'b1;
                                state_reg    <= S_CLEAR;
                            end
                            default: begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (clr_addr_reg == KEY_LAST) begin
                        clr_out_reg <= 1'b0;
                        res_reg     <= KS_NONE;
                        state_reg   <= clr_out_reg ? S_OUT : S_IDLE;
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                S_LOOKUP: begin
                    if (pend_we) begin
                        count_reg <= CW'(count_reg + 1'b1);
                    end
                    if (out_free) begin
                        m_tdata_reg  <= query_state;
                        state_reg    <= S_IDLE;
                    end else begin
                        res_reg   <= query_state;
                        state_reg <= S_OUT;
                    end
                end
                S_TICK_KEY: begin
                    tkey_reg  <= pend_rdata_reg;
                    state_reg <= S_TICK_SET;
                end
                S_TICK_SET: begin
                    if (idx_inc == count_reg) begin
                        count_reg <= '0;
                        res_reg   <= KS_NONE;
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_TICK_KEY;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "key_press_state_tracker_assert.svh"

    `KPST_ASSERT(a_count_bound, count_reg <= PEND_FULL, "pending count above depth")
    `KPST_ASSERT(a_wdata_code, key_we |-> key_wdata <= KS_FLAP, "bad key state written")
    `KPST_ASSERT(a_tick_idx, state_reg == S_TICK_KEY |-> idx_reg < count_reg, "tick index past list")
    `KPST_ASSERT(a_no_rw_clash, key_re && key_we |-> state_reg == S_IDLE, "key memory access clash")
    `KPST_ASSERT_ALWAYS(a_clear_blocks, state_reg == S_CLEAR |-> !s_tready, "word taken in sweep")

endmodule

`default_nettype wire
